// File: hdl/fog_pkg.sv
package fog_pkg;

    localparam int GRID_COLS = 16;
    localparam int GRID_ROWS = 16;

    localparam int COORD_W = 12;
    localparam int CFG_DATA_W = 12;
    localparam int REG_IDX_W = 1;

    localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int DIV_CNT_W = $clog2(COORD_W + 1);

    localparam logic [CFG_DATA_W-1:0] IMAGE_COLS_RST = 12'd640;
    localparam logic [CFG_DATA_W-1:0] IMAGE_ROWS_RST = 12'd480;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;

    localparam logic [1:0] OP_MARK = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ROW_OFF_ABOVE = 2'd0;
    localparam logic [1:0] ROW_OFF_CENTER = 2'd1;
    localparam logic [1:0] ROW_OFF_BELOW = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } fog_in_t;

    typedef struct packed {
        logic is_new;
        logic out_of_grid;
    } fog_out_t;

    typedef struct packed {
        logic       item_load;
        logic       div_start;
        logic       map_clear;
        logic       map_rd;
        logic [1:0] row_off;
        logic       map_wr;
        logic       res_load;
    } fog_cmd_t;

    typedef struct packed {
        logic       div_busy;
        logic [1:0] op;
        logic       oog;
    } fog_sts_t;

endpackage

// File: hdl/fog_div.sv
module fog_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fog_pkg::COORD_W-1:0] dividend,
    input  logic [fog_pkg::COORD_W-1:0] divisor,
    output logic                        busy,
    output logic [fog_pkg::COORD_W-1:0] quotient
);
    import fog_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [COORD_W-1:0]   dvd_reg;
    logic [COORD_W-1:0]   dvs_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic [COORD_W:0]     shifted;
    logic [COORD_W+1:0]   diff;

    assign shifted = {rem_reg, dvd_reg[COORD_W-1]};
    assign diff = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= DIV_CNT_W'(COORD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= diff[COORD_W+1] ? shifted[COORD_W-1:0] : diff[COORD_W-1:0];
            dvd_reg <= {dvd_reg[COORD_W-2:0], ~diff[COORD_W+1]};
        end
    end

    assign busy = busy_reg;
    assign quotient = dvd_reg;

endmodule

// File: hdl/fog_map.sv
module fog_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clr,
    input  logic                          rd_en,
    input  logic [fog_pkg::ROW_W-1:0]     rd_addr,
    output logic [fog_pkg::GRID_COLS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [fog_pkg::ROW_W-1:0]     wr_addr,
    input  logic [fog_pkg::GRID_COLS-1:0] wr_data
);
    import fog_pkg::*;

    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] row_vld_reg;
    logic [GRID_COLS-1:0] rd_raw_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (clr) begin
            row_vld_reg <= '0;
        end else if (wr_en) begin
            row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem[rd_addr];
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

// File: hdl/fog_dp.sv
module fog_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fog_pkg::fog_in_t               s_data,
    input  logic                           cfg_wr_en,
    input  logic [fog_pkg::REG_IDX_W-1:0]  cfg_idx,
    input  logic [fog_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  fog_pkg::fog_cmd_t              cmd,
    output fog_pkg::fog_sts_t              sts,
    output fog_pkg::fog_out_t              m_data
);
    import fog_pkg::*;

    logic [CFG_DATA_W-1:0] image_cols_reg;
    logic [CFG_DATA_W-1:0] image_rows_reg;
    fog_in_t               item_reg;
    fog_out_t              out_reg;
    logic                  any_reg;
    logic                  rd_pend_reg;

    logic [COORD_W-1:0]    cw;
    logic [COORD_W-1:0]    ch;
    logic [COORD_W-1:0]    dx_dividend;
    logic [COORD_W-1:0]    dx_divisor;
    logic [COORD_W-1:0]    dy_dividend;
    logic [COORD_W-1:0]    dy_divisor;
    logic [COORD_W-1:0]    qx;
    logic [COORD_W-1:0]    qy;
    logic                  busy_x;
    logic                  busy_y;
    logic                  oog;
    logic [COL_W-1:0]      cx;
    logic [ROW_W-1:0]      cy;
    logic [ROW_W+1:0]      row_sum;
    logic                  row_ok;
    logic [ROW_W-1:0]      row_addr;
    logic [GRID_COLS-1:0]  col_mask;
    logic [GRID_COLS-1:0]  rd_data;
    logic [GRID_COLS-1:0]  wr_data;
    logic                  rd_en;
    logic                  is_mark;
    logic                  is_query;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_cols_reg <= IMAGE_COLS_RST;
            image_rows_reg <= IMAGE_ROWS_RST;
        end else if (cfg_wr_en) begin
            if (cfg_idx == REG_IMAGE_COLS) begin
                image_cols_reg <= cfg_wdata;
            end
            if (cfg_idx == REG_IMAGE_ROWS) begin
                image_rows_reg <= cfg_wdata;
            end
        end
    end

    assign cw = COORD_W'(image_cols_reg / GRID_COLS);
    assign ch = COORD_W'(image_rows_reg / GRID_ROWS);

    assign dx_dividend = item_reg.x;
    assign dx_divisor = cw;
    assign dy_dividend = item_reg.y;
    assign dy_divisor = ch;

    fog_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dx_dividend),
        .divisor  (dx_divisor),
        .busy     (busy_x),
        .quotient (qx)
    );

    fog_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dy_dividend),
        .divisor  (dy_divisor),
        .busy     (busy_y),
        .quotient (qy)
    );

    assign oog = (cw == '0) || (ch == '0)
              || (qx >= COORD_W'(GRID_COLS)) || (qy >= COORD_W'(GRID_ROWS));
    assign cx = qx[COL_W-1:0];
    assign cy = qy[ROW_W-1:0];

    assign row_sum = {2'b00, cy} + {{ROW_W{1'b0}}, cmd.row_off};
    assign row_ok = (row_sum != '0) && (row_sum <= (ROW_W+2)'(GRID_ROWS));
    assign row_addr = ROW_W'(row_sum - 1'b1);
    assign rd_en = cmd.map_rd && row_ok;

    always_comb begin
        for (int i = 0; i < GRID_COLS; i++) begin
            col_mask[i] = ((COL_W+2)'(i) + 1'b1 >= {2'b00, cx})
                       && ((COL_W+2)'(i) <= {2'b00, cx} + 1'b1);
        end
    end

    assign wr_data = rd_data | (GRID_COLS'(1) << cx);

    fog_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (cmd.map_clear),
        .rd_en   (rd_en),
        .rd_addr (row_addr),
        .rd_data (rd_data),
        .wr_en   (cmd.map_wr),
        .wr_addr (cy),
        .wr_data (wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        if (cmd.div_start) begin
            any_reg <= 1'b0;
        end else if (rd_pend_reg && ((rd_data & col_mask) != '0)) begin
            any_reg <= 1'b1;
        end
        if (cmd.res_load) begin
            out_reg.is_new <= is_query && !oog && !any_reg;
            out_reg.out_of_grid <= (is_mark || is_query) && oog;
        end
    end

    assign is_mark = (item_reg.op == OP_MARK);
    assign is_query = (item_reg.op == OP_QUERY);

    assign sts.div_busy = busy_x || busy_y;
    assign sts.op = item_reg.op;
    assign sts.oog = oog;
    assign m_data = out_reg;

endmodule

// File: hdl/fog_ctrl.sv
module fog_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              cfg_wr_en,
    input  fog_pkg::fog_sts_t sts,
    output fog_pkg::fog_cmd_t cmd
);
    import fog_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITEM,
        ST_DIV_WAIT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_QRD,
        ST_QLAST,
        ST_RESP
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] row_cnt_reg;
    logic [1:0] row_cnt_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_ready = (state_reg == ST_IDLE) && !cfg_wr_en;

    always_comb begin
        state_next = state_reg;
        row_cnt_next = row_cnt_reg;
        cmd = '0;
        cmd.row_off = ROW_OFF_CENTER;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_ready && s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next = ST_ITEM;
                end
            end
            ST_ITEM: begin
                if (sts.op == OP_MARK || sts.op == OP_QUERY) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV_WAIT;
                end else if (sts.op == OP_CLEAR) begin
                    cmd.map_clear = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_DIV_WAIT: begin
                if (!sts.div_busy) begin
                    if (sts.oog) begin
                        state_next = ST_RESP;
                    end else if (sts.op == OP_MARK) begin
                        state_next = ST_MARK_RD;
                    end else begin
                        row_cnt_next = ROW_OFF_ABOVE;
                        state_next = ST_QRD;
                    end
                end
            end
            ST_MARK_RD: begin
                cmd.map_rd = 1'b1;
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.map_wr = 1'b1;
                state_next = ST_RESP;
            end
            ST_QRD: begin
                cmd.map_rd = 1'b1;
                cmd.row_off = row_cnt_reg;
                row_cnt_next = row_cnt_reg + 1'b1;
                if (row_cnt_reg == ROW_OFF_BELOW) begin
                    state_next = ST_QLAST;
                end
            end
            ST_QLAST: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_cnt_reg <= ROW_OFF_ABOVE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_cnt_reg <= row_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/feature_occupancy_grid_top.sv
// Feature occupancy grid: a bitmap of grid cells over an image, one bit per cell.
// Input channel (s_valid/s_ready/s_data): one beat carries op, x, y.
//   mark sets the cell of (x, y); query asks whether that cell and its in-bounds
//   3x3 neighbourhood are all clear; clear empties the whole map.
// Result channel (m_valid/m_ready/m_data): exactly one beat per input beat,
//   carrying is_new and out_of_grid, in input order.
// Config port (cfg_wr_en/cfg_idx/cfg_wdata): index 0 image_cols, 1 image_rows.
//   Cell sizes follow the registers at once; s_ready is low in a write cycle.
//   Write only while no beat is in flight.
// Path from accept to m_valid: clear and unused ops go straight to the result;
//   mark and query go through two 12-bit restoring dividers (one bit per cycle,
//   x and y in parallel), and an out-of-grid beat ends there; a mark then reads
//   and writes its map row, a query reads three map rows, one per cycle.
// One beat is in flight at a time; the next is taken in idle, after the result loads.
// Reset: the map is cleared at once, the size registers return to 640 x 480,
//   and s_ready is high once reset has put the controller in its idle state.
// Stall: the result register holds a finished beat while m_ready is low; the
//   next beat is accepted and worked on, and waits only to load that register.
module feature_occupancy_grid_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fog_pkg::fog_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fog_pkg::fog_out_t              m_data,
    input  logic                           cfg_wr_en,
    input  logic [fog_pkg::REG_IDX_W-1:0]  cfg_idx,
    input  logic [fog_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import fog_pkg::*;

    fog_cmd_t cmd;
    fog_sts_t sts;

    fog_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr_en (cfg_wr_en),
        .sts       (sts),
        .cmd       (cmd)
    );

    fog_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule
